@@ hw/rtl/rhc_pkg.sv @@
// rhc_pkg: shared types, constants and the known-tag lookup for the header classifier
// depends on nothing; imported by rhc_front, rhc_queue, rhc_back and the top level
`default_nettype none

package rhc_pkg;

    localparam int KNOWN_CODES = 22;
    // payload length field in the queue entry, sized for the largest supported payload
    localparam int LEN_W       = 16;
    // tag count field in the queue entry, sized for the largest supported tag table
    localparam int NSEL_W      = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [31:0] KNOWN_TAGS [KNOWN_CODES] = '{
        32'h00444150, 32'h00474953, 32'h00524556, 32'h31545544,
        32'h434e4f4e, 32'h454c4544, 32'h48544150, 32'h49415444,
        32'h49444152, 32'h4b425550, 32'h5041454c, 32'h5044494d,
        32'h50455253, 32'h544e494d, 32'h544f4f52, 32'h54524543,
        32'h5458414d, 32'h58444e49, 32'hFF444150, 32'hFF474953,
        32'hFF524556, 32'h7a7a7a7a
    };

    typedef enum logic [1:0] {
        OP_NONE,
        OP_OFFSET,
        OP_TAG
    } t_word_op;

    typedef struct packed {
        logic [31:0]       dword;
        t_word_op          op;
        logic              first;
        logic              last;
        logic [LEN_W-1:0]  len;
        logic              pre_ok;
        logic              multi;
        logic [NSEL_W-1:0] n_small;
    } t_rhc_entry;

    function automatic logic code_is_known(input logic [31:0] code, input int unsigned limit);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KNOWN_CODES; k++) begin
            if ((k < limit) && (KNOWN_TAGS[k] == code)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rhc_front.sv @@
// rhc_front: takes payload bytes, gathers little-endian dwords and classifies each one
// depends on rhc_pkg; pushes one entry per accepted byte into rhc_queue
`default_nettype none

module rhc_front #(
    parameter int MAX_PAYLOAD_BYTES = 65535,
    parameter int TAG_TABLE_SIZE    = 22
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [7:0]          i_payload_byte,
    input  wire logic                i_first_byte,
    input  wire logic                i_last_byte,
    input  wire logic                i_full,
    output logic                     o_push,
    output rhc_pkg::t_rhc_entry      o_entry
);
    import rhc_pkg::*;

    localparam int POS_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int IDX_W = POS_W - 2;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PAYLOAD_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_asm, n_asm;
    logic [31:0]      r_tag_count, n_tag_count;

    logic             accept;
    logic [POS_W-1:0] base_pos;
    logic [31:0]      base_asm;
    logic [31:0]      base_n;
    logic             room;
    logic [1:0]       lane;
    logic [IDX_W-1:0] idx;
    logic [31:0]      asm_new;
    logic             dword_done;
    logic [POS_W-1:0] pos_new;
    logic [32:0]      idx_ext;
    logic [32:0]      n_ext;
    logic             is_count;
    logic             is_off;
    logic             is_tag;
    logic [31:0]      n_eff;
    logic             len_ge4;
    logic             n_ok;
    logic             len_ge8n;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    always_comb begin
        // a start marker clears the state before the byte is taken
        base_pos = i_first_byte ? '0    : r_pos;
        base_asm = i_first_byte ? 32'd0 : r_asm;
        base_n   = i_first_byte ? 32'd0 : r_tag_count;

        room = base_pos < POS_MAX;
        lane = base_pos[1:0];
        idx  = base_pos[POS_W-1:2];

        asm_new    = room ? (base_asm | (32'(i_payload_byte) << {lane, 3'b000})) : base_asm;
        dword_done = room && (lane == 2'd3);
        pos_new    = room ? (base_pos + POS_W'(1)) : base_pos;

        idx_ext = 33'(idx);
        n_ext   = 33'(base_n);

        is_count = dword_done && (idx == '0);
        is_off   = dword_done && (idx != '0) && (base_n >= 32'd2) && (idx_ext == (n_ext - 33'd1));
        is_tag   = dword_done && (idx != '0) && (idx_ext >= n_ext) && (idx_ext < (n_ext << 1));

        n_eff = is_count ? asm_new : base_n;

        // length checks that need only the count
        len_ge4  = pos_new >= POS_W'(4);
        n_ok     = (n_eff != 32'd0) && (n_eff <= 32'(TAG_TABLE_SIZE));
        len_ge8n = 35'(pos_new) >= {n_eff, 3'b000};
    end

    always_comb begin
        o_push          = accept;
        o_entry.dword   = asm_new;
        o_entry.op      = is_off ? OP_OFFSET : (is_tag ? OP_TAG : OP_NONE);
        o_entry.first   = i_first_byte;
        o_entry.last    = i_last_byte;
        o_entry.len     = LEN_W'(pos_new);
        o_entry.pre_ok  = len_ge4 && n_ok && len_ge8n;
        o_entry.multi   = n_eff > 32'd1;
        o_entry.n_small = n_eff[NSEL_W-1:0];
    end

    always_comb begin
        n_pos       = r_pos;
        n_asm       = r_asm;
        n_tag_count = r_tag_count;
        if (accept) begin
            if (i_last_byte) begin
                n_pos       = '0;
                n_asm       = 32'd0;
                n_tag_count = 32'd0;
            end else begin
                n_pos       = pos_new;
                n_asm       = dword_done ? 32'd0 : asm_new;
                n_tag_count = n_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_asm       <= 32'd0;
            r_tag_count <= 32'd0;
        end else begin
            r_pos       <= n_pos;
            r_asm       <= n_asm;
            r_tag_count <= n_tag_count;
        end
    end

`ifndef SYNTHESIS
    // a verdict byte leaves the front ready for a fresh payload
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_pos == '0) && (r_tag_count == 32'd0))
        else $error("front state not cleared after last byte");
    // position never runs past the saturation point
    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("byte position beyond maximum");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rhc_queue.sv @@
// rhc_queue: short fifo of classified entries between front and back
// depends on rhc_pkg for the entry type and depth
`default_nettype none

module rhc_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  rhc_pkg::t_rhc_entry      i_entry,
    output logic                     o_full,
    output logic                     o_valid,
    output rhc_pkg::t_rhc_entry      o_entry,
    input  wire logic                i_pop
);
    import rhc_pkg::*;

    t_rhc_entry        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? (r_wr_ptr + QPTR_W'(1)) : r_wr_ptr;
        n_rd_ptr = i_pop  ? (r_rd_ptr + QPTR_W'(1)) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rhc_back.sv @@
// rhc_back: tag lookup, last-offset capture and the final verdict with its output register
// depends on rhc_pkg for the entry type and the known-tag table
`default_nettype none

module rhc_back #(
    parameter int TAG_TABLE_SIZE = 22
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  rhc_pkg::t_rhc_entry      i_entry,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic                     o_is_match,
    input  wire logic                i_stall
);
    import rhc_pkg::*;

    localparam int unsigned TABLE_LIMIT =
        (TAG_TABLE_SIZE < KNOWN_CODES) ? TAG_TABLE_SIZE : KNOWN_CODES;

    logic        r_unknown,   n_unknown;
    logic [31:0] r_last_off,  n_last_off;
    logic        r_out_valid, n_out_valid;
    logic        r_is_match,  n_is_match;

    logic        can_take;
    logic        base_unknown;
    logic [31:0] base_off;
    logic        known;
    logic        eff_unknown;
    logic [31:0] eff_off;
    logic [33:0] need_len;
    logic        len_ok;
    logic        verdict;

    always_comb begin
        // entries without a verdict never wait on the output
        can_take = !i_entry.last || !r_out_valid || !i_stall;
        o_pop    = i_valid && can_take;

        base_unknown = i_entry.first ? 1'b0  : r_unknown;
        base_off     = i_entry.first ? 32'd0 : r_last_off;

        known       = code_is_known(i_entry.dword, TABLE_LIMIT);
        eff_unknown = base_unknown || ((i_entry.op == OP_TAG) && !known);
        eff_off     = (i_entry.op == OP_OFFSET) ? i_entry.dword : base_off;

        need_len = (34'(i_entry.n_small) << 2) + 34'(eff_off);
        len_ok   = !i_entry.multi || (34'(i_entry.len) >= need_len);
        verdict  = i_entry.pre_ok && len_ok && !eff_unknown;
    end

    always_comb begin
        n_unknown   = r_unknown;
        n_last_off  = r_last_off;
        n_out_valid = r_out_valid && i_stall;
        n_is_match  = r_is_match;
        if (o_pop) begin
            if (i_entry.last) begin
                n_unknown   = 1'b0;
                n_last_off  = 32'd0;
                n_out_valid = 1'b1;
                n_is_match  = verdict;
            end else begin
                n_unknown  = eff_unknown;
                n_last_off = eff_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unknown   <= 1'b0;
            r_last_off  <= 32'd0;
            r_out_valid <= 1'b0;
            r_is_match  <= 1'b0;
        end else begin
            r_unknown   <= n_unknown;
            r_last_off  <= n_last_off;
            r_out_valid <= n_out_valid;
            r_is_match  <= n_is_match;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_is_match = r_is_match;

`ifndef SYNTHESIS
    a_verdict_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |=> o_valid)
        else $error("verdict entry did not load the output");
    a_failed_precheck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last && !i_entry.pre_ok) |=> !o_is_match)
        else $error("match despite failed length or count check");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/roughtime_header_classifier_top.sv @@
// roughtime_header_classifier_top: byte-stream classifier for message headers
// depends on rhc_pkg, rhc_front, rhc_queue and rhc_back
`default_nettype none

// Takes a packet payload one byte per word on the input channel and gives one
// verdict word (o_is_match) for each byte marked last. Bytes form little-endian
// dwords: dword 0 is the tag count N, dwords 1..N-1 are offsets (the last one is
// kept), dwords N..2N-1 are tags checked against the known-tag table. A match
// needs length >= 4, 1 <= N <= TAG_TABLE_SIZE, length >= 8N, for N > 1 length
// >= 4N + last offset, and all tags known. A start marker restarts the payload;
// after a verdict the next byte starts a new payload with or without a marker.
// The byte count saturates at MAX_PAYLOAD_BYTES; later bytes are ignored.
// Rate: one byte per clock while o_stall is low. The front takes a byte every cycle while
// the four-entry queue has room; the verdict entry passes through the queue and is then
// loaded into the output register, which holds it while i_stall is high.
// Output stalls block only verdict entries, so up to four bytes are absorbed
// before o_stall rises.
module roughtime_header_classifier_top #(
    parameter int MAX_PAYLOAD_BYTES = 65535,
    parameter int TAG_TABLE_SIZE    = 22
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    // verdict output channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_is_match
);
    import rhc_pkg::*;

    // classified entry travelling from front to back
    t_rhc_entry push_entry;
    t_rhc_entry pop_entry;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_valid;

    // front: byte gathering, dword classification, count-based length checks
    rhc_front #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
        .TAG_TABLE_SIZE    (TAG_TABLE_SIZE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_payload_byte (i_payload_byte),
        .i_first_byte   (i_first_byte),
        .i_last_byte    (i_last_byte),
        .i_full         (q_full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    // decoupling queue so output stalls do not hold the byte stream at once
    rhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (pop_entry),
        .i_pop   (pop)
    );

    // back: tag table lookup, offset check and registered verdict
    rhc_back #(
        .TAG_TABLE_SIZE (TAG_TABLE_SIZE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_entry    (pop_entry),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_is_match (o_is_match),
        .i_stall    (i_stall)
    );

endmodule

`default_nettype wire
